/* rtl/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg: shared definitions for the source text tokenizer
// Token kinds, scan modes, byte codes, keyword table and character classes.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  // Widths and defaults
  localparam int KIND_W            = 5;
  localparam int LEN_W             = 8;
  localparam int OFFSET_BITS_DEF   = 20;
  localparam int KEYWORD_COUNT_DEF = 7;
  localparam int KW_SLOTS          = 16;
  localparam int QUEUE_DEPTH_DEF   = 4;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 8'd32;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_IDENT  = 5'd0;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 5'd1;
  localparam logic [KIND_W-1:0] KIND_CLASS  = 5'd2;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 5'd9;
  localparam logic [KIND_W-1:0] KIND_EQ     = 5'd10;
  localparam logic [KIND_W-1:0] KIND_LE     = 5'd11;
  localparam logic [KIND_W-1:0] KIND_GE     = 5'd12;
  localparam logic [KIND_W-1:0] KIND_NE     = 5'd13;
  localparam logic [KIND_W-1:0] KIND_LT     = 5'd14;
  localparam logic [KIND_W-1:0] KIND_GT     = 5'd15;
  localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd16;
  localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd17;
  localparam logic [KIND_W-1:0] KIND_STAR   = 5'd18;
  localparam logic [KIND_W-1:0] KIND_SLASH  = 5'd19;
  localparam logic [KIND_W-1:0] KIND_MOD    = 5'd20;
  localparam logic [KIND_W-1:0] KIND_NOT    = 5'd21;
  localparam logic [KIND_W-1:0] KIND_TILDE  = 5'd22;
  localparam logic [KIND_W-1:0] KIND_LPAR   = 5'd23;
  localparam logic [KIND_W-1:0] KIND_RPAR   = 5'd24;
  localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd25;
  localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd26;
  localparam logic [KIND_W-1:0] KIND_DOT    = 5'd27;
  localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd28;
  localparam logic [KIND_W-1:0] KIND_SEMI   = 5'd29;
  localparam logic [KIND_W-1:0] KIND_END    = 5'd30;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 5'd31;

  // Byte codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_MOD    = 8'h25;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // Scan modes
  typedef enum logic [8:0] {
    MODE_IDLE    = 9'b000000001,
    MODE_NUMBER  = 9'b000000010,
    MODE_NAME    = 9'b000000100,
    MODE_SLASH   = 9'b000001000,
    MODE_COMMENT = 9'b000010000,
    MODE_LT      = 9'b000100000,
    MODE_GT      = 9'b001000000,
    MODE_EQ      = 9'b010000000,
    MODE_BANG    = 9'b100000000
  } mode_t;

  // Valid flags for up to two tokens handed from the scanner to the output queue together
  typedef struct packed {
    logic first_valid;
    logic second_valid;
  } push_t;

  // Character classes
  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z], CH_UNDER, CH_DOLLAR};
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c inside {CH_SPACE, CH_LF, CH_TAB, CH_CR};
  endfunction

  // Kind of a one-byte operator; anything unknown is an error
  function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    case (c)
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_MOD:    k = KIND_MOD;
      CH_TILDE:  k = KIND_TILDE;
      CH_LPAR:   k = KIND_LPAR;
      CH_RPAR:   k = KIND_RPAR;
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_DOT:    k = KIND_DOT;
      CH_COMMA:  k = KIND_COMMA;
      CH_SEMI:   k = KIND_SEMI;
      default:   k = KIND_ERROR;
    endcase
    return k;
  endfunction

  // Keyword lengths; unused slots have length zero and never match
  function automatic logic [2:0] kw_len(input int k);
    logic [2:0] l;
    case (k)
      0:       l = 3'd5;
      1:       l = 3'd6;
      2:       l = 3'd7;
      3:       l = 3'd6;
      4:       l = 3'd3;
      5:       l = 3'd4;
      6:       l = 3'd5;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

  // Keyword text, first byte in the top bits
  function automatic logic [63:0] kw_text(input int k);
    logic [63:0] t;
    case (k)
      0:       t = {"class",   24'h0};
      1:       t = {"public",  16'h0};
      2:       t = {"boolean",  8'h0};
      3:       t = {"double",  16'h0};
      4:       t = {"for",     40'h0};
      5:       t = {"true",    32'h0};
      6:       t = {"false",   24'h0};
      default: t = 64'h0;
    endcase
    return t;
  endfunction

  // Per-slot match of byte c at position i of the current name
  function automatic logic [KW_SLOTS-1:0] kw_match(input logic [LEN_W-1:0] i,
                                                   input logic [7:0] c);
    logic [KW_SLOTS-1:0] m;
    logic [63:0]         t;
    for (int k = 0; k < KW_SLOTS; k++) begin
      t    = kw_text(k);
      m[k] = (i < LEN_W'(kw_len(k))) && (t[8*(7-int'(i[2:0])) +: 8] == c);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/stt_scan.sv */
// ----------------------------------------------------------------------------
// stt_scan: byte register and token scanner
// Registers one text byte, then in a single pass updates the scan state and
// produces up to two tokens for the output queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_scan #(
  parameter int OFFSET_BITS   = stt_pkg::OFFSET_BITS_DEF,
  parameter int KEYWORD_COUNT = stt_pkg::KEYWORD_COUNT_DEF,
  parameter int TOK_W         = stt_pkg::KIND_W + 2 * OFFSET_BITS + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          text_valid,
  output logic                               text_ready,
  input  wire logic [7:0]                    text_byte,
  input  wire logic [stt_pkg::LEN_W-1:0]     max_len,
  input  wire logic                          room,
  output stt_pkg::push_t                     push,
  output logic [TOK_W-1:0]                   tok_first,
  output logic [TOK_W-1:0]                   tok_second
);

  localparam logic [OFFSET_BITS-1:0]   POS_MAX   = {OFFSET_BITS{1'b1}};
  localparam logic [KEYWORD_COUNT-1:0] ALL_FLAGS = {KEYWORD_COUNT{1'b1}};

  // Byte register
  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;

  // Scan state
  stt_pkg::mode_t                mode, mode_next;
  logic [OFFSET_BITS-1:0]        pos, pos_next;
  logic [OFFSET_BITS-1:0]        tstart, tstart_next;
  logic [stt_pkg::LEN_W-1:0]     tlen, tlen_next;
  logic [KEYWORD_COUNT-1:0]      flags, flags_next;
  logic                          too_long, too_long_next;

  // Working signals
  logic [OFFSET_BITS-1:0]        cur, nx;
  logic [stt_pkg::KW_SLOTS-1:0]  match_cont, match_fresh;
  logic [KEYWORD_COUNT-1:0]      app_flags, fresh_flags;
  logic                          at_limit;
  logic [stt_pkg::KIND_W-1:0]    name_kind;
  logic                          has_a, has_b, do_idle;
  logic [stt_pkg::KIND_W-1:0]    kind_a, kind_b;
  logic [OFFSET_BITS-1:0]        end_a;
  logic [stt_pkg::KIND_W-1:0]    single_kind, pair_kind;
  logic [TOK_W-1:0]              tok_a, tok_b;

  assign advance    = in_full && room;
  assign text_ready = !in_full || advance;

  // Hold the byte until the queue has room for its tokens
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (text_ready) begin
      in_full <= text_valid;
    end
    if (text_ready && text_valid) begin
      in_byte <= text_byte;
    end
  end

  // Offsets and keyword flags
  assign cur         = pos;
  assign nx          = (pos == POS_MAX) ? POS_MAX : pos + 1'b1;
  assign match_cont  = stt_pkg::kw_match(tlen, in_byte);
  assign match_fresh = stt_pkg::kw_match('0, in_byte);
  assign app_flags   = flags & match_cont[KEYWORD_COUNT-1:0];
  assign fresh_flags = match_fresh[KEYWORD_COUNT-1:0];
  assign at_limit    = tlen >= max_len;

  // Resolve a finished name: first keyword whose text and length agree; an overlong name is an error
  always_comb begin
    name_kind = stt_pkg::KIND_IDENT;
    for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
      if (flags[k] && tlen == stt_pkg::LEN_W'(stt_pkg::kw_len(k))) begin
        name_kind = stt_pkg::KIND_W'(int'(stt_pkg::KIND_CLASS) + k);
      end
    end
    if (too_long) begin
      name_kind = stt_pkg::KIND_ERROR;
    end
  end

  // Operator pair kinds for the lookahead modes
  always_comb begin
    case (mode)
      stt_pkg::MODE_LT: begin
        single_kind = stt_pkg::KIND_LT;
        pair_kind   = stt_pkg::KIND_LE;
      end
      stt_pkg::MODE_GT: begin
        single_kind = stt_pkg::KIND_GT;
        pair_kind   = stt_pkg::KIND_GE;
      end
      stt_pkg::MODE_EQ: begin
        single_kind = stt_pkg::KIND_ASSIGN;
        pair_kind   = stt_pkg::KIND_EQ;
      end
      default: begin
        single_kind = stt_pkg::KIND_NOT;
        pair_kind   = stt_pkg::KIND_NE;
      end
    endcase
  end

  // One pass: close the pending token, then handle the byte from idle
  always_comb begin
    mode_next     = mode;
    pos_next      = nx;
    tstart_next   = tstart;
    tlen_next     = tlen;
    flags_next    = flags;
    too_long_next = too_long;
    has_a         = 1'b0;
    has_b         = 1'b0;
    do_idle       = 1'b0;
    kind_a        = stt_pkg::KIND_ERROR;
    kind_b        = stt_pkg::KIND_ERROR;
    end_a         = cur;

    case (mode)
      stt_pkg::MODE_NUMBER: begin
        if (stt_pkg::is_digit(in_byte)) begin
          flags_next    = app_flags;
          too_long_next = too_long || at_limit;
          tlen_next     = at_limit ? tlen : tlen + 1'b1;
        end else begin
          has_a   = 1'b1;
          kind_a  = too_long ? stt_pkg::KIND_ERROR : stt_pkg::KIND_NUMBER;
          do_idle = 1'b1;
        end
      end
      stt_pkg::MODE_NAME: begin
        if (stt_pkg::is_digit(in_byte) || stt_pkg::is_letter(in_byte)) begin
          flags_next    = app_flags;
          too_long_next = too_long || at_limit;
          tlen_next     = at_limit ? tlen : tlen + 1'b1;
        end else begin
          has_a   = 1'b1;
          kind_a  = name_kind;
          do_idle = 1'b1;
        end
      end
      stt_pkg::MODE_SLASH: begin
        if (in_byte == stt_pkg::CH_SLASH) begin
          mode_next = stt_pkg::MODE_COMMENT;
        end else begin
          has_a   = 1'b1;
          kind_a  = (max_len == '0) ? stt_pkg::KIND_ERROR : stt_pkg::KIND_SLASH;
          do_idle = 1'b1;
        end
      end
      stt_pkg::MODE_COMMENT: begin
        if (in_byte == stt_pkg::CH_LF) begin
          mode_next = stt_pkg::MODE_IDLE;
        end else if (in_byte == stt_pkg::CH_NUL) begin
          do_idle = 1'b1;
        end
      end
      stt_pkg::MODE_LT, stt_pkg::MODE_GT, stt_pkg::MODE_EQ, stt_pkg::MODE_BANG: begin
        has_a = 1'b1;
        if (in_byte == stt_pkg::CH_EQ) begin
          kind_a        = (max_len < 8'd2) ? stt_pkg::KIND_ERROR : pair_kind;
          end_a         = nx;
          mode_next     = stt_pkg::MODE_IDLE;
          tstart_next   = cur;
          tlen_next     = '0;
          too_long_next = 1'b0;
          flags_next    = ALL_FLAGS;
        end else begin
          kind_a  = (max_len == '0) ? stt_pkg::KIND_ERROR : single_kind;
          do_idle = 1'b1;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // Start a fresh token at this byte
    if (do_idle) begin
      mode_next     = stt_pkg::MODE_IDLE;
      tstart_next   = cur;
      tlen_next     = '0;
      too_long_next = 1'b0;
      flags_next    = ALL_FLAGS;
      if (stt_pkg::is_blank(in_byte)) begin
        mode_next = stt_pkg::MODE_IDLE;
      end else if (stt_pkg::is_digit(in_byte) || stt_pkg::is_letter(in_byte)) begin
        mode_next     = stt_pkg::is_digit(in_byte) ? stt_pkg::MODE_NUMBER
                                                   : stt_pkg::MODE_NAME;
        flags_next    = fresh_flags;
        too_long_next = (max_len == '0);
        tlen_next     = (max_len == '0) ? '0 : stt_pkg::LEN_W'(1);
      end else begin
        case (in_byte)
          stt_pkg::CH_SLASH: mode_next = stt_pkg::MODE_SLASH;
          stt_pkg::CH_LT:    mode_next = stt_pkg::MODE_LT;
          stt_pkg::CH_GT:    mode_next = stt_pkg::MODE_GT;
          stt_pkg::CH_EQ:    mode_next = stt_pkg::MODE_EQ;
          stt_pkg::CH_BANG:  mode_next = stt_pkg::MODE_BANG;
          stt_pkg::CH_NUL: begin
            // End of text: rewind for the next text
            has_b       = 1'b1;
            kind_b      = stt_pkg::KIND_END;
            pos_next    = '0;
            tstart_next = '0;
          end
          default: begin
            has_b  = 1'b1;
            kind_b = (max_len == '0) ? stt_pkg::KIND_ERROR
                                     : stt_pkg::op_kind(in_byte);
          end
        endcase
      end
    end
  end

  // Pack tokens; the last one of this byte carries the run mark
  assign tok_a = {kind_a, tstart, end_a, !has_b};
  assign tok_b = {kind_b, cur, nx, 1'b1};

  always_comb begin
    push.first_valid  = advance && (has_a || has_b);
    push.second_valid = advance && has_a && has_b;
    tok_first         = has_a ? tok_a : tok_b;
    tok_second        = tok_b;
  end

  // Advance scan state on each byte taken
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= stt_pkg::MODE_IDLE;
      pos      <= '0;
      tstart   <= '0;
      tlen     <= '0;
      flags    <= ALL_FLAGS;
      too_long <= 1'b0;
    end else if (advance) begin
      mode     <= mode_next;
      pos      <= pos_next;
      tstart   <= tstart_next;
      tlen     <= tlen_next;
      flags    <= flags_next;
      too_long <= too_long_next;
    end
  end

  // Checks
  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    push.second_valid |-> push.first_valid)
    else $error("second token pushed without a first");

  a_nul_gives_token: assert property (@(posedge clk) disable iff (rst)
    advance && in_byte == stt_pkg::CH_NUL |-> push.first_valid)
    else $error("end of text produced no token");

  a_nul_rewinds: assert property (@(posedge clk) disable iff (rst)
    advance && in_byte == stt_pkg::CH_NUL |=> pos == '0 && mode == stt_pkg::MODE_IDLE)
    else $error("end of text did not rewind the scanner");

endmodule

`default_nettype wire

/* rtl/stt_outq.sv */
// ----------------------------------------------------------------------------
// stt_outq: token output queue
// Small register queue that takes up to two tokens a cycle while it has room and hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_outq #(
  parameter int WIDTH = 46,
  parameter int DEPTH = stt_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire stt_pkg::push_t   push,
  input  wire logic [WIDTH-1:0] din_first,
  input  wire logic [WIDTH-1:0] din_second,
  output logic                  room,
  output logic                  dout_valid,
  input  wire logic             dout_ready,
  output logic [WIDTH-1:0]      dout
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PTR_W-1:0] head, tail, tail_plus;
  logic [CNT_W-1:0] count;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign tail_plus  = ptr_inc(tail);
  assign room       = count <= CNT_W'(DEPTH - 2);
  assign dout_valid = count != '0;
  assign pop        = dout_valid && dout_ready;
  assign dout       = entry[head];

  // Store incoming tokens at the tail
  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      entry[tail] <= din_first;
    end
    if (push.second_valid) begin
      entry[tail_plus] <= din_second;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= ptr_inc(head);
      end
      if (push.second_valid) begin
        tail <= ptr_inc(tail_plus);
      end else if (push.first_valid) begin
        tail <= tail_plus;
      end
      count <= count + CNT_W'(push.first_valid) + CNT_W'(push.second_valid)
             - CNT_W'(pop);
    end
  end

  // Checks
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.first_valid |-> count <= CNT_W'(DEPTH - 2))
    else $error("tokens pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue occupancy out of range");

endmodule

`default_nettype wire

/* rtl/source_text_tokenizer.sv */
// ----------------------------------------------------------------------------
// source_text_tokenizer: streaming lexer for source text
// Splits a byte stream into tokens with kind and start/end byte offsets.
//
//   channel   direction  handshake                 payload
//   text      in         text_valid / text_ready   text_byte
//   token     out        token_valid / token_ready token_kind, start_offset,
//                                                  end_offset, last_of_run
//   cfg       in         cfg_write (no wait)       cfg_data = max token length
//
// One byte is taken per cycle while the output queue has room. A byte gives
// zero, one or two tokens; the token port moves one per cycle while
// token_ready is high, so a run of bytes that each close a token and start
// another is held back once the queue fills. A taken byte waits in the byte
// register, and its tokens are written to the queue and offered from there.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer #(
  parameter int OFFSET_BITS   = stt_pkg::OFFSET_BITS_DEF,
  parameter int KEYWORD_COUNT = stt_pkg::KEYWORD_COUNT_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         text_valid,
  output logic                              text_ready,
  input  wire logic [7:0]                   text_byte,
  output logic                              token_valid,
  input  wire logic                         token_ready,
  output logic [stt_pkg::KIND_W-1:0]        token_kind,
  output logic [OFFSET_BITS-1:0]            start_offset,
  output logic [OFFSET_BITS-1:0]            end_offset,
  output logic                              last_of_run,
  input  wire logic                         cfg_write,
  input  wire logic [stt_pkg::LEN_W-1:0]    cfg_data
);

  localparam int TOK_W = stt_pkg::KIND_W + 2 * OFFSET_BITS + 1;

  logic [stt_pkg::LEN_W-1:0] max_len;
  logic                      room;
  stt_pkg::push_t            push;
  logic [TOK_W-1:0]          tok_first, tok_second, tok_out;

  // Hold the length limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= stt_pkg::MAX_LEN_RESET;
    end else if (cfg_write) begin
      max_len <= cfg_data;
    end
  end

  stt_scan #(
    .OFFSET_BITS   (OFFSET_BITS),
    .KEYWORD_COUNT (KEYWORD_COUNT),
    .TOK_W         (TOK_W)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_byte  (text_byte),
    .max_len    (max_len),
    .room       (room),
    .push       (push),
    .tok_first  (tok_first),
    .tok_second (tok_second)
  );

  stt_outq #(
    .WIDTH (TOK_W),
    .DEPTH (stt_pkg::QUEUE_DEPTH_DEF)
  ) u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .din_first  (tok_first),
    .din_second (tok_second),
    .room       (room),
    .dout_valid (token_valid),
    .dout_ready (token_ready),
    .dout       (tok_out)
  );

  // Split the queued token into its fields
  assign token_kind   = tok_out[TOK_W-1 -: stt_pkg::KIND_W];
  assign start_offset = tok_out[2*OFFSET_BITS -: OFFSET_BITS];
  assign end_offset   = tok_out[OFFSET_BITS -: OFFSET_BITS];
  assign last_of_run  = tok_out[0];

endmodule

`default_nettype wire

/* bench/tb_source_text_tokenizer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_source_text_tokenizer: self-checking bench for the source text tokenizer
// Feeds texts (a short hand-built one, then random token streams ending in a
// zero byte) under several length limits. Every accepted byte runs through a
// bit-accurate lexer mirror that queues the tokens it should cause, and every
// token taken from the block is checked against the oldest queued one.
// ----------------------------------------------------------------------------

module tb_source_text_tokenizer;
  import stt_pkg::*;

  localparam int OFF_W          = OFFSET_BITS_DEF;
  localparam int KW_N           = KEYWORD_COUNT_DEF;
  localparam int DRAIN_CYCLES   = 8;
  localparam int LONG_HOLD      = 150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_BYTES    = 210;
  localparam int SHOWN_ERRORS   = 10;
  localparam logic [7:0] UNKNOWN_BYTE = 8'hFF;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  start_at;
    logic [OFF_W-1:0]  end_at;
    logic              last;
  } token_t;

  // Lexer mirror: tracks scan state and queues the tokens each byte causes
  class token_tracker;
    string            kw_word [KW_N];
    token_t           awaited_tokens [$];
    mode_t            mode;
    logic [OFF_W-1:0] pos;
    logic [OFF_W-1:0] tok_start;
    logic [LEN_W-1:0] tok_len;
    logic [LEN_W-1:0] len_limit;
    logic [KW_N-1:0]  kw_live;
    bit               overlong;
    int               bytes_taken;
    int               tokens_checked;
    int               mismatches;
    int               twin_bytes;
    logic [31:0]      kinds_seen;

    function new();
      kw_word = '{"class", "public", "boolean", "double", "for", "true", "false"};
      len_limit = MAX_LEN_RESET;
      pos = '0;
      kinds_seen = '0;
      open_token('0, MODE_IDLE);
    endfunction

    function bit digit_char(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit name_char(logic [7:0] c);
      return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
             c == CH_UNDER || c == CH_DOLLAR;
    endfunction

    function bit space_char(logic [7:0] c);
      return c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_CR;
    endfunction

    function logic [OFF_W-1:0] bump(logic [OFF_W-1:0] p);
      return (p == '1) ? p : p + 1'b1;
    endfunction

    function logic [KIND_W-1:0] lone_kind(logic [7:0] c);
      case (c)
        CH_PLUS:   return KIND_PLUS;
        CH_MINUS:  return KIND_MINUS;
        CH_STAR:   return KIND_STAR;
        CH_MOD:    return KIND_MOD;
        CH_TILDE:  return KIND_TILDE;
        CH_LPAR:   return KIND_LPAR;
        CH_RPAR:   return KIND_RPAR;
        CH_LBRACE: return KIND_LBRACE;
        CH_RBRACE: return KIND_RBRACE;
        CH_DOT:    return KIND_DOT;
        CH_COMMA:  return KIND_COMMA;
        CH_SEMI:   return KIND_SEMI;
        default:   return KIND_ERROR;
      endcase
    endfunction

    function logic [KIND_W-1:0] sized(logic [KIND_W-1:0] kind, int n);
      return (n > len_limit) ? KIND_ERROR : kind;
    endfunction

    function void open_token(logic [OFF_W-1:0] at, mode_t m);
      mode = m;
      tok_start = at;
      tok_len = '0;
      overlong = 1'b0;
      kw_live = '1;
    endfunction

    // Drop keywords that stop matching; stop counting at the limit
    function void add_char(logic [7:0] c);
      for (int k = 0; k < KW_N; k++)
        if (!(tok_len < kw_word[k].len() && kw_word[k][tok_len] == c))
          kw_live[k] = 1'b0;
      if (tok_len >= len_limit) overlong = 1'b1;
      else tok_len++;
    endfunction

    function logic [KIND_W-1:0] name_result();
      if (overlong) return KIND_ERROR;
      for (int k = 0; k < KW_N; k++)
        if (kw_live[k] && tok_len == kw_word[k].len()) return KIND_CLASS + KIND_W'(k);
      return KIND_IDENT;
    endfunction

    function void push(logic [KIND_W-1:0] kind, logic [OFF_W-1:0] s, logic [OFF_W-1:0] e);
      token_t t;
      t.kind = kind;
      t.start_at = s;
      t.end_at = e;
      t.last = 1'b0;
      awaited_tokens.push_back(t);
    endfunction

    // Handle a byte with no token pending
    function void fresh_byte(logic [7:0] c, logic [OFF_W-1:0] at);
      logic [OFF_W-1:0] nxt;
      nxt = bump(at);
      open_token(at, MODE_IDLE);
      if (digit_char(c)) begin
        mode = MODE_NUMBER;
        add_char(c);
      end else if (name_char(c)) begin
        mode = MODE_NAME;
        add_char(c);
      end else if (!space_char(c)) begin
        case (c)
          CH_SLASH: mode = MODE_SLASH;
          CH_LT:    mode = MODE_LT;
          CH_GT:    mode = MODE_GT;
          CH_EQ:    mode = MODE_EQ;
          CH_BANG:  mode = MODE_BANG;
          CH_NUL: begin
            push(KIND_END, at, nxt);
            pos = '0;
            open_token('0, MODE_IDLE);
          end
          default:  push(sized(lone_kind(c), 1), at, nxt);
        endcase
      end
    endfunction

    function void note_byte(logic [7:0] c);
      logic [OFF_W-1:0]  cur;
      logic [OFF_W-1:0]  nxt;
      logic [KIND_W-1:0] lone;
      logic [KIND_W-1:0] twin;
      bit                pair;
      int                queued_prior;
      token_t            t;
      cur = pos;
      nxt = bump(cur);
      queued_prior = awaited_tokens.size();
      pos = nxt;
      pair = 1'b0;
      lone = KIND_ERROR;
      twin = KIND_ERROR;
      bytes_taken++;
      case (mode)
        MODE_NUMBER: begin
          if (digit_char(c)) add_char(c);
          else begin
            push(overlong ? KIND_ERROR : KIND_NUMBER, tok_start, cur);
            fresh_byte(c, cur);
          end
        end
        MODE_NAME: begin
          if (digit_char(c) || name_char(c)) add_char(c);
          else begin
            push(name_result(), tok_start, cur);
            fresh_byte(c, cur);
          end
        end
        MODE_SLASH: begin
          if (c == CH_SLASH) mode = MODE_COMMENT;
          else begin
            push(sized(KIND_SLASH, 1), tok_start, cur);
            fresh_byte(c, cur);
          end
        end
        MODE_COMMENT: begin
          if (c == CH_LF) mode = MODE_IDLE;
          else if (c == CH_NUL) fresh_byte(c, cur);
        end
        MODE_LT: begin
          pair = 1'b1; lone = KIND_LT; twin = KIND_LE;
        end
        MODE_GT: begin
          pair = 1'b1; lone = KIND_GT; twin = KIND_GE;
        end
        MODE_EQ: begin
          pair = 1'b1; lone = KIND_ASSIGN; twin = KIND_EQ;
        end
        MODE_BANG: begin
          pair = 1'b1; lone = KIND_NOT; twin = KIND_NE;
        end
        default: fresh_byte(c, cur);
      endcase
      // Settle the one-byte lookahead
      if (pair) begin
        if (c == CH_EQ) begin
          push(sized(twin, 2), tok_start, nxt);
          open_token(cur, MODE_IDLE);
        end else begin
          push(sized(lone, 1), tok_start, cur);
          fresh_byte(c, cur);
        end
      end
      // Mark the final token of this byte
      if (awaited_tokens.size() > queued_prior) begin
        t = awaited_tokens.pop_back();
        t.last = 1'b1;
        awaited_tokens.push_back(t);
      end
      if (awaited_tokens.size() - queued_prior == 2) twin_bytes++;
    endfunction

    function void check_token(token_t got);
      token_t want;
      if (awaited_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("unexpected token: kind %0d span %0d..%0d last %0d",
                   got.kind, got.start_at, got.end_at, got.last);
        return;
      end
      want = awaited_tokens.pop_front();
      tokens_checked++;
      kinds_seen[want.kind] = 1'b1;
      if (got.kind !== want.kind || got.start_at !== want.start_at ||
          got.end_at !== want.end_at || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("token %0d: expected kind %0d span %0d..%0d last %0d, got kind %0d span %0d..%0d last %0d",
                   tokens_checked, want.kind, want.start_at, want.end_at, want.last,
                   got.kind, got.start_at, got.end_at, got.last);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     text_valid = 1'b0;
  logic                     text_ready;
  logic [7:0]               text_byte = '0;
  logic                     token_valid;
  logic                     token_ready = 1'b0;
  logic [KIND_W-1:0]        token_kind;
  logic [OFF_W-1:0]         start_offset;
  logic [OFF_W-1:0]         end_offset;
  logic                     last_of_run;
  logic                     cfg_write = 1'b0;
  logic [LEN_W-1:0]         cfg_data = '0;

  token_tracker tracker = new();
  logic [7:0]   text_q [$];
  logic [7:0]   op_set [13] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_MOD, CH_TILDE, CH_LPAR,
                                CH_RPAR, CH_LBRACE, CH_RBRACE, CH_DOT, CH_COMMA,
                                CH_SEMI, CH_SLASH};
  logic [7:0]   pair_set [4] = '{CH_LT, CH_GT, CH_EQ, CH_BANG};
  logic [7:0]   blank_set [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
  bit           long_hold_due = 1'b0;
  int           send_calm = 0;
  int           settings_used = 1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  source_text_tokenizer i_dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .text_byte    (text_byte),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token_kind   (token_kind),
    .start_offset (start_offset),
    .end_offset   (end_offset),
    .last_of_run  (last_of_run),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data)
  );

  // Mostly no gap, some short ones, a few long; now and then a calm stretch
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 999);
    if (r < 15) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 650) return 0;
    if (r < 900) return $urandom_range(1, 3);
    if (r < 980) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] any_letter();
    int r;
    r = $urandom_range(0, 53);
    if (r < 26) return CH_LO_A + 8'(r);
    if (r < 52) return CH_UP_A + 8'(r - 26);
    return (r == 52) ? CH_UNDER : CH_DOLLAR;
  endfunction

  function automatic logic [7:0] any_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic void add_word(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // Number or name run of n bytes
  function automatic void add_run(bit numeric, int n);
    text_q.push_back(numeric ? any_digit() : any_letter());
    for (int i = 1; i < n; i++)
      text_q.push_back((numeric || $urandom_range(0, 3) == 0) ? any_digit() : any_letter());
  endfunction

  // Length right at the limit or just past it
  function automatic int long_len(logic [7:0] limit);
    return $urandom_range((limit > 0) ? limit : 1, limit + 2);
  endfunction

  function automatic int pick_len(logic [7:0] limit, int typical);
    if ($urandom_range(0, 29) == 0) return long_len(limit);
    return $urandom_range(1, typical);
  endfunction

  function automatic void add_piece(logic [7:0] limit);
    int         r;
    logic [7:0] c;
    string      w;
    r = $urandom_range(0, 99);
    w = tracker.kw_word[$urandom_range(0, KW_N - 1)];
    if (r < 14) add_word(w);
    else if (r < 20) begin
      // near-miss keyword: a prefix or one byte too many
      if ($urandom_range(0, 1)) add_word(w.substr(0, $urandom_range(0, w.len() - 2)));
      else begin
        add_word(w);
        text_q.push_back($urandom_range(0, 1) ? any_letter() : any_digit());
      end
    end
    else if (r < 34) add_run(1'b0, pick_len(limit, 8));
    else if (r < 46) add_run(1'b1, pick_len(limit, 6));
    else if (r < 62) text_q.push_back(op_set[$urandom_range(0, 12)]);
    else if (r < 74) begin
      text_q.push_back(pair_set[$urandom_range(0, 3)]);
      if ($urandom_range(0, 9) < 6) text_q.push_back(CH_EQ);
    end
    else if (r < 80) begin
      // line comment with any body byte but newline and zero
      text_q.push_back(CH_SLASH);
      text_q.push_back(CH_SLASH);
      repeat ($urandom_range(0, 10)) begin
        c = 8'($urandom_range(1, 254));
        if (c >= CH_LF) c++;
        text_q.push_back(c);
      end
      text_q.push_back(CH_LF);
    end
    else if (r < 88) repeat ($urandom_range(1, 3)) text_q.push_back(blank_set[$urandom_range(0, 3)]);
    else if (r < 96) text_q.push_back(8'($urandom_range(1, 255)));
    else text_q.push_back(CH_NUL);
  endfunction

  function automatic void build_text(logic [7:0] limit, bit lead_long);
    text_q.delete();
    if (lead_long) begin
      add_run($urandom_range(0, 1), long_len(limit));
      text_q.push_back(CH_SPACE);
    end
    repeat ($urandom_range(3, 15)) begin
      add_piece(limit);
      if ($urandom_range(0, 1)) text_q.push_back(blank_set[$urandom_range(0, 3)]);
    end
    // sometimes leave a comment open at end of text
    if ($urandom_range(0, 6) == 0) begin
      text_q.push_back(CH_SLASH);
      text_q.push_back(CH_SLASH);
      text_q.push_back(any_letter());
    end
    text_q.push_back(CH_NUL);
  endfunction

  // Offer one byte and hold it until the request is taken
  task automatic push_byte(logic [7:0] b);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_byte  <= b;
    @(posedge clk);
    while (!text_ready) @(posedge clk);
  endtask

  task automatic send_text();
    foreach (text_q[i]) push_byte(text_q[i]);
  endtask

  // Drop valid, wait until every token is back, then let the pipe empty
  task automatic settle();
    text_valid <= 1'b0;
    do @(posedge clk); while (tracker.awaited_tokens.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_length_limit(logic [7:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    tracker.len_limit = v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(logic [7:0] limit, bit hold_midway);
    int sent;
    bit lead;
    set_length_limit(limit);
    settings_used++;
    sent = 0;
    lead = 1'b1;
    while (sent < PHASE_BYTES) begin
      build_text(limit, lead);
      lead = 1'b0;
      foreach (text_q[i]) begin
        push_byte(text_q[i]);
        sent++;
        if (hold_midway && sent == 40) long_hold_due = 1'b1;
      end
    end
    settle();
  endtask

  // Check tokens and note bytes as their requests are taken
  always @(posedge clk) begin
    if (!rst) begin
      if (token_valid && token_ready)
        tracker.check_token(token_t'({token_kind, start_offset, end_offset, last_of_run}));
      if (text_valid && text_ready) tracker.note_byte(text_byte);
    end
  end

  // Token receiver: random stalls plus an occasional long hold-off
  initial begin : token_sink
    int stall;
    int calm;
    calm = 0;
    forever begin
      @(posedge clk);
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = pick_gap(calm);
      end
      if (stall > 0) begin
        token_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      token_ready <= 1'b1;
    end
  end

  // End the run if no request moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((text_valid && text_ready) || (token_valid && token_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] limits [7];
    limits = '{8'd0, 8'd1, 8'd255, 8'd3, 8'd7, 8'd16, 8'd16};
    limits[5] = 8'($urandom_range(2, 254));
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Hand-built text at the reset limit: keyword, lookahead pairs and
    // singles, slash then name, open comment at end, unknown byte
    text_q.delete();
    add_word("for==9<=b>=!=</x!y>;//q");
    text_q.push_back(CH_NUL);
    text_q.push_back(UNKNOWN_BYTE);
    text_q.push_back(CH_NUL);
    send_text();
    settle();

    foreach (limits[i]) run_phase(limits[i], i == 1 || i == 4);

    if (tracker.awaited_tokens.size() != 0)
      $display("%0d expected tokens never arrived", tracker.awaited_tokens.size());
    $display("covered %0d text bytes under %0d length limits; %0d tokens checked, %0d mismatches",
             tracker.bytes_taken, settings_used, tracker.tokens_checked, tracker.mismatches);
    $display("%0d of 32 token kinds seen; %0d bytes closed one token and gave another",
             $countones(tracker.kinds_seen), tracker.twin_bytes);
    if (tracker.mismatches == 0 && tracker.awaited_tokens.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
